@@ hw/rtl/bpfa_pkg.sv @@
// Shared types and constants of the bitmap page frame allocator.
`default_nettype none

package bpfa_pkg;

	localparam int FRAME_W  = 52;
	localparam int COUNT_W  = 13;
	localparam int CFG_IDX_W = 1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_FRAME   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_FRAMES = 1'b1;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_FREE = 2'd1,
		ST_RANGE   = 2'd2,
		ST_DOUBLE  = 2'd3
	} status_t;

	// Classified request handed from the front end to the back end.
	typedef struct packed {
		op_t                op;
		logic               hi_ok;
		logic [COUNT_W-1:0] off;
	} cmd_t;

	// Result beat; frame_out sits in the lowest bits.
	typedef struct packed {
		logic [COUNT_W-1:0] free_pages;
		logic [COUNT_W-1:0] used_pages;
		status_t            status;
		logic [FRAME_W-1:0] frame_out;
	} res_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_PICK,
		BK_DIV,
		BK_READ,
		BK_EXEC
	} bk_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/bpfa_front.sv @@
// Front end: accepts request beats and classifies them into commands.
`default_nettype none

module bpfa_front
	import bpfa_pkg::*;
(
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [FRAME_W-1:0] frame_in,
	input  wire logic               op_in,
	input  wire logic [FRAME_W-1:0] base_frame,
	input  wire logic               q_ready,
	input  wire logic               clearing,
	output logic                    push,
	output cmd_t                    cmd
);

	logic [FRAME_W-1:0] offset;

	// The offset wraps modulo 2^52; only offsets below 2^13 can be in range.
	assign offset   = frame_in - base_frame;
	assign s_tready = q_ready && !clearing;
	assign push     = s_tvalid && s_tready;

	always_comb begin
		cmd.op    = op_t'(op_in);
		cmd.hi_ok = (offset[FRAME_W-1:COUNT_W] == '0);
		cmd.off   = offset[COUNT_W-1:0];
	end

endmodule

`default_nettype wire

@@ hw/rtl/bpfa_queue.sv @@
// Two-entry command queue between the front end and the back end.
`default_nettype none

module bpfa_queue #(
	parameter int WIDTH = 15
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] din,
	output logic                  ready,
	input  wire logic             pop,
	output logic                  valid,
	output logic [WIDTH-1:0]      dout
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign ready   = (count_q != CNT_W'(DEPTH));
	assign valid   = (count_q != '0);
	assign dout    = entry_q[rd_ptr_q];
	assign do_push = push && ready;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/bpfa_back.sv @@
// Back end: bitmap memory, free-word search, update and result register.
`default_nettype none

module bpfa_back
	import bpfa_pkg::*;
#(
	parameter int MAX_FRAMES = 4096,
	parameter int WORD_BITS  = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_valid,
	input  wire cmd_t               q_cmd,
	output logic                    q_pop,
	input  wire logic [FRAME_W-1:0] base_frame,
	input  wire logic [$clog2(MAX_FRAMES/WORD_BITS+1)-1:0] words,
	input  wire logic [COUNT_W-1:0] managed,
	output logic                    clearing,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output res_t                    res
);

	localparam int NUM_WORDS = MAX_FRAMES / WORD_BITS;
	localparam int WC_W      = $clog2(NUM_WORDS + 1);
	localparam int WI_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int BI_W      = $clog2(WORD_BITS);
	localparam int K         = COUNT_W + BI_W;
	localparam int RECIP     = ((1 << K) + WORD_BITS - 1) / WORD_BITS;
	localparam int RECIP_W   = $clog2(RECIP + 1);
	localparam int PROD_W    = COUNT_W + RECIP_W;
	localparam int NGROUPS   = (NUM_WORDS + 7) / 8;
	localparam int GI_W      = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
	localparam int PW_W      = GI_W + 3;
	localparam int FO_W      = $clog2(MAX_FRAMES + 1);

	bk_state_t state_q, state_d;

	logic [WORD_BITS-1:0] mem_q [NUM_WORDS];
	logic [WORD_BITS-1:0] rdata_q;
	logic [WI_W-1:0]      clr_q;
	logic [NUM_WORDS-1:0] full_q;
	logic [COUNT_W-1:0]   used_q;
	logic                 out_valid_q;
	res_t                 res_q;

	op_t                  op_q;
	logic [COUNT_W-1:0]   off_q;
	logic                 range_ok_q;
	logic [PROD_W-1:0]    prod_o_q;
	logic [WI_W-1:0]      w_q;
	logic [BI_W-1:0]      b_q;
	status_t              status_q;

	logic [NGROUPS-1:0]   grp_any_s1;
	logic [NGROUPS*3-1:0] grp_idx_s1;
	logic [NGROUPS*8-1:0] avail;
	logic [NGROUPS-1:0]   grp_any_c;
	logic [NGROUPS*3-1:0] grp_idx_c;

	logic                 pick_found;
	logic [PW_W-1:0]      pick_wide;
	logic [COUNT_W-1:0]   div_q;
	logic [WI_W-1:0]      div_w;
	logic [BI_W-1:0]      div_b;

	logic [WORD_BITS-1:0] inv;
	logic [WORD_BITS-1:0] low;
	logic [BI_W-1:0]      alloc_b;
	logic [WORD_BITS-1:0] new_word;
	logic                 new_full;
	logic                 do_write;
	logic [COUNT_W-1:0]   used_d;
	status_t              st_d;
	logic [FO_W-1:0]      frame_off;
	logic [FRAME_W-1:0]   frame_d;
	logic [COUNT_W-1:0]   free_d;

	logic                 fire;
	logic                 rd_en;
	logic                 wr_en;
	logic [WI_W-1:0]      wr_addr;
	logic [WORD_BITS-1:0] wr_data;

	assign clearing = (state_q == BK_CLEAR);
	assign m_tvalid = out_valid_q;
	assign res      = res_q;

	// A word can take an allocation if it is not full and lies in the managed range.
	always_comb begin
		avail = '0;
		for (int i = 0; i < NUM_WORDS; i++) begin
			avail[i] = !full_q[i] && (WC_W'(i) < words);
		end
	end

	// First search level: any free word per group of eight, and the lowest one.
	always_comb begin
		for (int g = 0; g < NGROUPS; g++) begin
			grp_any_c[g]       = |avail[g*8 +: 8];
			grp_idx_c[g*3 +: 3] = 3'd0;
			for (int j = 7; j >= 0; j--) begin
				if (avail[g*8 + j]) begin
					grp_idx_c[g*3 +: 3] = 3'(j);
				end
			end
		end
	end

	// Second search level: the lowest group that has a free word.
	always_comb begin
		pick_found = 1'b0;
		pick_wide  = '0;
		for (int g = NGROUPS - 1; g >= 0; g--) begin
			if (grp_any_s1[g]) begin
				pick_found = 1'b1;
				pick_wide  = PW_W'(g * 8) | PW_W'(grp_idx_s1[g*3 +: 3]);
			end
		end
	end

	// Offset split into word and bit by a reciprocal multiply, exact for 13-bit offsets.
	assign div_q = COUNT_W'(prod_o_q >> K);
	assign div_w = WI_W'(div_q);
	assign div_b = BI_W'(off_q - COUNT_W'(div_q * COUNT_W'(WORD_BITS)));

	// Word update: isolate the lowest clear bit for an allocation, or clear the freed bit for a free.
	always_comb begin
		inv      = ~rdata_q;
		low      = inv & (~inv + WORD_BITS'(1));
		alloc_b  = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (low[i]) begin
				alloc_b = alloc_b | BI_W'(i);
			end
		end
		new_word  = rdata_q | low;
		new_full  = &(rdata_q | low);
		do_write  = 1'b0;
		used_d    = used_q;
		st_d      = status_q;
		frame_off = FO_W'(w_q) * FO_W'(WORD_BITS) + FO_W'(alloc_b);
		frame_d   = '0;
		if (status_q == ST_OK) begin
			if (op_q == OP_ALLOC) begin
				do_write = 1'b1;
				used_d   = used_q + COUNT_W'(1);
				frame_d  = base_frame + FRAME_W'(frame_off);
			end else if (!rdata_q[b_q]) begin
				st_d = ST_DOUBLE;
			end else begin
				do_write = 1'b1;
				new_word = rdata_q & ~(WORD_BITS'(1) << b_q);
				new_full = 1'b0;
				used_d   = used_q - COUNT_W'(1);
			end
		end
		free_d = (managed > used_d) ? (managed - used_d) : '0;
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		rd_en   = 1'b0;
		wr_en   = 1'b0;
		fire    = 1'b0;
		wr_addr = w_q;
		wr_data = new_word;
		case (state_q)
			BK_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
				if (clr_q == WI_W'(NUM_WORDS - 1)) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = (q_cmd.op == OP_ALLOC) ? BK_PICK : BK_DIV;
				end
			end
			BK_PICK: begin
				state_d = pick_found ? BK_READ : BK_EXEC;
			end
			BK_DIV: begin
				state_d = range_ok_q ? BK_READ : BK_EXEC;
			end
			BK_READ: begin
				rd_en   = 1'b1;
				state_d = BK_EXEC;
			end
			BK_EXEC: begin
				if (!out_valid_q || m_tready) begin
					fire    = 1'b1;
					wr_en   = do_write;
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			full_q      <= '0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == BK_CLEAR) begin
				clr_q <= clr_q + WI_W'(1);
			end
			if (fire) begin
				out_valid_q <= 1'b1;
				used_q      <= used_d;
				if (do_write) begin
					full_q[w_q] <= new_full;
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		grp_any_s1 <= grp_any_c;
		grp_idx_s1 <= grp_idx_c;
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					op_q       <= q_cmd.op;
					off_q      <= q_cmd.off;
					range_ok_q <= q_cmd.hi_ok && (q_cmd.off < managed);
					prod_o_q   <= PROD_W'(q_cmd.off) * PROD_W'(RECIP);
				end
			end
			BK_PICK: begin
				w_q      <= WI_W'(pick_wide);
				status_q <= pick_found ? ST_OK : ST_NO_FREE;
			end
			BK_DIV: begin
				w_q      <= div_w;
				b_q      <= div_b;
				status_q <= range_ok_q ? ST_OK : ST_RANGE;
			end
			default: begin
			end
		endcase
		if (fire) begin
			res_q.frame_out  <= frame_d;
			res_q.status     <= st_d;
			res_q.used_pages <= used_d;
			res_q.free_pages <= free_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem_q[w_q];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/bitmap_page_frame_allocator.sv @@
// Top level of the bitmap page frame allocator: configuration, front end, queue, back end.
`default_nettype none

// Channel   Direction  Beat fields (lowest bit first)
// s_*       in         tdata: frame_in[51:0], zero pad to 56; tuser: op
// m_*       out        tdata: frame_out[51:0], status[1:0], used_pages[12:0], free_pages[12:0]
// cfg_*     in         index 0 base_frame, index 1 total_frames; one write per cycle
//
// An allocation runs through the group stage of the free-word search, group select, bitmap
// read and word update. A free runs through range check, word/bit split, read and update.
// No free frame or an out-of-range free skips the read; a double free still reads.
// Each request depends on the previous bitmap update.
// After reset a clearing pass writes all MAX_FRAMES/WORD_BITS words while s_tready is low.
// A two-entry queue keeps taking beats while a finished result waits on m_tready.

module bitmap_page_frame_allocator
	import bpfa_pkg::*;
#(
	parameter int MAX_FRAMES = 4096,
	parameter int WORD_BITS  = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [FRAME_W-1:0]   cfg_wdata,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [55:0]          s_tdata,  // frame_in[51:0], zero pad
	input  wire logic [0:0]           s_tuser,  // op
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [79:0]               m_tdata   // frame_out, status, used_pages, free_pages
);

	localparam int NUM_WORDS = MAX_FRAMES / WORD_BITS;
	localparam int WC_W      = $clog2(NUM_WORDS + 1);
	localparam int BI_W      = $clog2(WORD_BITS);
	localparam int K         = COUNT_W + BI_W;
	localparam int RECIP     = ((1 << K) + WORD_BITS - 1) / WORD_BITS;
	localparam int RECIP_W   = $clog2(RECIP + 1);
	localparam int PROD_W    = COUNT_W + RECIP_W;
	localparam int MAXF_W    = $clog2(MAX_FRAMES + 1);
	localparam int CMP_W     = (MAXF_W > COUNT_W) ? MAXF_W : COUNT_W;
	localparam int RST_TOTAL = 4096;
	localparam int RST_NMIN  = (RST_TOTAL > MAX_FRAMES) ? MAX_FRAMES : RST_TOTAL;
	localparam int RST_PROD  = RST_NMIN * RECIP;
	localparam int RST_WORDS = RST_NMIN / WORD_BITS;
	localparam int RST_MNGD  = RST_WORDS * WORD_BITS;

	logic [FRAME_W-1:0] base_frame_q;
	logic [PROD_W-1:0]  geo_prod_q;
	logic [WC_W-1:0]    words_q;
	logic [COUNT_W-1:0] managed_q;
	logic [COUNT_W-1:0] wr_total;
	logic [COUNT_W-1:0] wr_nmin;
	logic [WC_W-1:0]    words_c;

	logic               clearing;
	logic               q_ready;
	logic               q_valid;
	logic               q_pop;
	logic               push;
	cmd_t               cmd_in;
	cmd_t               cmd_out;
	res_t               res;

	// The managed count is the configured count, capped at MAX_FRAMES and rounded down to
	// whole words. The reciprocal product is registered at the write, and the word and managed
	// counts are registered from it; the user must hold requests until they settle, unenforced.
	assign wr_total = cfg_wdata[COUNT_W-1:0];
	assign wr_nmin  = (CMP_W'(wr_total) > CMP_W'(MAX_FRAMES)) ? COUNT_W'(MAX_FRAMES)
	                                                          : wr_total;
	assign words_c  = WC_W'(geo_prod_q >> K);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_frame_q <= '0;
			geo_prod_q   <= PROD_W'(RST_PROD);
			words_q      <= WC_W'(RST_WORDS);
			managed_q    <= COUNT_W'(RST_MNGD);
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_BASE_FRAME: begin
						base_frame_q <= cfg_wdata;
					end
					CFG_TOTAL_FRAMES: begin
						geo_prod_q <= PROD_W'(wr_nmin) * PROD_W'(RECIP);
					end
					default: begin
					end
				endcase
			end
			words_q   <= words_c;
			managed_q <= COUNT_W'(COUNT_W'(words_c) * COUNT_W'(WORD_BITS));
		end
	end

	bpfa_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.frame_in   (s_tdata[FRAME_W-1:0]),
		.op_in      (s_tuser[0]),
		.base_frame (base_frame_q),
		.q_ready    (q_ready),
		.clearing   (clearing),
		.push       (push),
		.cmd        (cmd_in)
	);

	bpfa_queue #(
		.WIDTH ($bits(cmd_t))
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (cmd_in),
		.ready  (q_ready),
		.pop    (q_pop),
		.valid  (q_valid),
		.dout   (cmd_out)
	);

	bpfa_back #(
		.MAX_FRAMES (MAX_FRAMES),
		.WORD_BITS  (WORD_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_cmd      (cmd_out),
		.q_pop      (q_pop),
		.base_frame (base_frame_q),
		.words      (words_q),
		.managed    (managed_q),
		.clearing   (clearing),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.res        (res)
	);

	assign m_tdata = res;

	// No request is taken while the bitmap is still being cleared.
	a_no_accept_while_clearing: assert property (
		@(posedge clk) disable iff (!arst_n) clearing |-> !s_tready
	) else $error("request beat accepted during the bitmap clearing pass");

	// Only a successful allocation carries a frame number.
	a_frame_zero_on_error: assert property (
		@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (res.status != ST_OK)) |-> (res.frame_out == '0)
	) else $error("rejected request returned a nonzero frame");

	// Used and free counts add up to the managed count unless free has saturated.
	a_counts_consistent: assert property (
		@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((res.free_pages == '0) ||
			(({1'b0, res.used_pages} + {1'b0, res.free_pages}) == {1'b0, managed_q}))
	) else $error("used and free page counts do not match the managed count");

endmodule

`default_nettype wire
